@@ rtl/spi_pkg.sv @@
// Package for the spectral power integrator: field widths, reset values,
// configuration register indexes and the per-item control struct.
// No dependencies.
`default_nettype none

package spi_pkg;

   // default sizes, handed to the top level parameters
   localparam int FFT_BINS_DEF  = 32;
   localparam int KEPT_BINS_DEF = 27;
   localparam int MAX_AVG_DEF   = 16;

   // fixed field widths
   localparam int IN_W       = 22;
   localparam int SQ_W       = 43;   // square of a 22-bit signed value
   localparam int POWER_W    = 45;   // sum of four squares
   localparam int TOTAL_W    = 49;   // per-bin total over the frames of a channel
   localparam int SUM_W      = 53;   // group sum
   localparam int GRP_W      = 16;
   localparam int AVG_W      = 5;
   localparam int CFG_W      = 5;
   localparam int REQ_DATA_W = 4 * IN_W;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_PAD_W  = RSP_DATA_W - SUM_W - GRP_W;

   localparam logic [CFG_W-1:0] TIME_AVG_RST = 5'd4;
   localparam logic [CFG_W-1:0] FREQ_AVG_RST = 5'd16;

   typedef enum logic {
      CSR_TIME_AVG = 1'b0,
      CSR_FREQ_AVG = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic             start;   // clear group state before this item
      logic             kept;    // bin below the kept range limit
      logic             last;    // last frame of the channel
      logic             first;   // first frame: start the bin total from zero
      logic [AVG_W-1:0] favg;    // effective frequency average
   } item_ctl_type;

endpackage

`default_nettype wire

@@ rtl/spi_power.sv @@
// Power detection pipeline: registers the four bin components, squares them
// and sums the squares. Valid/ready per stage. Depends on spi_pkg.
`default_nettype none

module spi_power import spi_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire item_ctl_type           in_ctl,
   input  wire logic signed [IN_W-1:0] in_i_re,
   input  wire logic signed [IN_W-1:0] in_i_im,
   input  wire logic signed [IN_W-1:0] in_q_re,
   input  wire logic signed [IN_W-1:0] in_q_im,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output item_ctl_type                out_ctl,
   output logic [POWER_W-1:0]          out_power
);

   logic                     v1_ff, v2_ff, v3_ff;
   logic                     rdy1, rdy2, rdy3;
   item_ctl_type             ctl1_ff, ctl2_ff, ctl3_ff;
   logic signed [IN_W-1:0]   comp_ff [4];
   logic signed [2*IN_W-1:0] prod    [4];
   logic [SQ_W-1:0]          sq_in   [4];
   logic [SQ_W-1:0]          sq_ff   [4];
   logic [POWER_W-1:0]       power_in;
   logic [POWER_W-1:0]       power_ff;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         prod[k]  = comp_ff[k] * comp_ff[k];
         sq_in[k] = prod[k][SQ_W-1:0];
      end
   end

   assign power_in = POWER_W'(sq_ff[0]) + POWER_W'(sq_ff[1])
                   + POWER_W'(sq_ff[2]) + POWER_W'(sq_ff[3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         ctl1_ff    <= in_ctl;
         comp_ff[0] <= in_i_re;
         comp_ff[1] <= in_i_im;
         comp_ff[2] <= in_q_re;
         comp_ff[3] <= in_q_im;
      end
      if (rdy2) begin
         ctl2_ff <= ctl1_ff;
         sq_ff   <= sq_in;
      end
      if (rdy3) begin
         ctl3_ff  <= ctl2_ff;
         power_ff <= power_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_ctl   = ctl3_ff;
   assign out_power = power_ff;

endmodule

`default_nettype wire

@@ rtl/spi_cell.sv @@
// One cell of the bin total ring: holds the running total of one kept bin
// and takes its neighbor's total on each shift. Depends on spi_pkg.
`default_nettype none

module spi_cell import spi_pkg::*; (
   input  wire logic               clock,
   input  wire logic               shift,
   input  wire logic [TOTAL_W-1:0] link_in,
   output logic [TOTAL_W-1:0]      value
);

   logic [TOTAL_W-1:0] value_ff;

   always_ff @(posedge clock) begin
      if (shift) value_ff <= link_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

@@ rtl/spi_group.sv @@
// Frequency grouping: adds final bin totals into the running group sum and
// loads the result register every freq_avg totals. Depends on spi_pkg.
`default_nettype none

module spi_group import spi_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire item_ctl_type         in_ctl,
   input  wire logic [TOTAL_W-1:0]   in_total,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [RSP_DATA_W-1:0]     rsp_tdata    // power_sum, group_number, zero pad
);

   logic [SUM_W-1:0] total_ff, total_in, base_total, sum;
   logic [AVG_W-1:0] fill_ff, fill_in, base_fill, fill_inc;
   logic [GRP_W-1:0] cnt_ff, cnt_in, base_cnt;
   logic             rsp_valid_ff;
   logic [SUM_W-1:0] power_ff;
   logic [GRP_W-1:0] number_ff;
   logic             out_free, take, hit, emit;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign in_ready = out_free;
   assign take     = in_valid && out_free;

   always_comb begin
      base_total = in_ctl.start ? '0 : total_ff;
      base_fill  = in_ctl.start ? '0 : fill_ff;
      base_cnt   = in_ctl.start ? '0 : cnt_ff;
      sum        = base_total + SUM_W'(in_total);
      fill_inc   = base_fill + AVG_W'(1);
      hit        = in_ctl.kept && in_ctl.last && (fill_inc >= in_ctl.favg);
      total_in   = base_total;
      fill_in    = base_fill;
      cnt_in     = base_cnt;
      if (in_ctl.kept && in_ctl.last) begin
         if (hit) begin
            total_in = '0;
            fill_in  = '0;
            cnt_in   = base_cnt + GRP_W'(1);
         end else begin
            total_in = sum;
            fill_in  = fill_inc;
         end
      end
   end

   assign emit = take && hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            total_ff <= total_in;
            fill_ff  <= fill_in;
            cnt_ff   <= cnt_in;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         power_ff  <= sum;
         number_ff <= base_cnt;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), number_ff, power_ff};

endmodule

`default_nettype wire

@@ rtl/spectral_power_integrator.sv @@
// Spectral power integrator, top level. Depends on spi_pkg, spi_power,
// spi_cell and spi_group.
// Throughput: one bin item per cycle, sustained while rsp_ is not stalled.
// Path: a result reaches rsp_ through five register stages after the item that
// completes its group is accepted, the first loaded at the accepting edge:
// input register, square, four-way sum, ring accumulate, group sum.
// Stalls on rsp_ back up through every stage.
// Reset (synchronous): counters, group state and configuration return to their
// defaults; the ring of bin totals is not cleared.
`default_nettype none

module spectral_power_integrator import spi_pkg::*; #(
   parameter int FFT_BINS  = FFT_BINS_DEF,
   parameter int KEPT_BINS = KEPT_BINS_DEF,
   parameter int MAX_AVG   = MAX_AVG_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // pol_i_re, pol_i_im, pol_q_re, pol_q_im
   input  wire logic [0:0]            req_tuser,   // block_start
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // power_sum, group_number, zero pad
   input  wire logic                  csr_wen,
   input  wire logic [0:0]            csr_index,
   input  wire logic [CFG_W-1:0]      csr_wdata
);

   localparam int BIN_W   = $clog2(FFT_BINS);
   localparam int FRAME_W = (MAX_AVG > 1) ? $clog2(MAX_AVG) : 1;
   localparam int NCELL   = (KEPT_BINS < FFT_BINS) ? KEPT_BINS : FFT_BINS;

   logic [CFG_W-1:0]   time_avg_ff, freq_avg_ff;
   logic [AVG_W-1:0]   tavg_eff, favg_eff;
   logic [BIN_W-1:0]   bin_pos_ff, bin_pos_in, cur_bin;
   logic [FRAME_W-1:0] frame_pos_ff, frame_pos_in, cur_frame;
   logic               accept, start, last, kept, bin_wrap;
   item_ctl_type       in_ctl;

   logic               pw_valid, pw_ready;
   item_ctl_type       pw_ctl;
   logic [POWER_W-1:0] pw_power;

   logic [TOTAL_W-1:0] cell_q   [NCELL];
   logic [TOTAL_W-1:0] chain_in [NCELL];
   logic [TOTAL_W-1:0] new_total;
   logic               ring_shift;

   logic               v4_ff, rdy4, grp_ready;
   item_ctl_type       ctl4_ff;
   logic [TOTAL_W-1:0] total4_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         time_avg_ff <= TIME_AVG_RST;
         freq_avg_ff <= FREQ_AVG_RST;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_TIME_AVG: time_avg_ff <= csr_wdata;
            CSR_FREQ_AVG: freq_avg_ff <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // zero acts as one, clamp to the largest average
   always_comb begin
      tavg_eff = AVG_W'(time_avg_ff);
      if (tavg_eff == '0) tavg_eff = AVG_W'(1);
      if (32'(tavg_eff) > MAX_AVG) tavg_eff = AVG_W'(MAX_AVG);
      favg_eff = AVG_W'(freq_avg_ff);
      if (favg_eff == '0) favg_eff = AVG_W'(1);
      if (32'(favg_eff) > MAX_AVG) favg_eff = AVG_W'(MAX_AVG);
   end

   // bin and frame position of the arriving item
   assign accept    = req_tvalid && req_tready;
   assign start     = req_tuser[0];
   assign cur_bin   = start ? '0 : bin_pos_ff;
   assign cur_frame = start ? '0 : frame_pos_ff;
   assign last      = (32'(cur_frame) + 1) >= 32'(tavg_eff);
   assign kept      = 32'(cur_bin) < KEPT_BINS;
   assign bin_wrap  = (cur_bin == BIN_W'(FFT_BINS - 1));

   always_comb begin
      bin_pos_in   = bin_wrap ? '0 : cur_bin + BIN_W'(1);
      frame_pos_in = cur_frame;
      if (bin_wrap) frame_pos_in = last ? '0 : cur_frame + FRAME_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_pos_ff   <= '0;
         frame_pos_ff <= '0;
      end else if (accept) begin
         bin_pos_ff   <= bin_pos_in;
         frame_pos_ff <= frame_pos_in;
      end
   end

   always_comb begin
      in_ctl.start = start;
      in_ctl.kept  = kept;
      in_ctl.last  = last;
      in_ctl.first = (cur_frame == '0);
      in_ctl.favg  = favg_eff;
   end

   spi_power u_power (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_ctl    (in_ctl),
      .in_i_re   (req_tdata[IN_W-1:0]),
      .in_i_im   (req_tdata[2*IN_W-1:IN_W]),
      .in_q_re   (req_tdata[3*IN_W-1:2*IN_W]),
      .in_q_im   (req_tdata[4*IN_W-1:3*IN_W]),
      .out_valid (pw_valid),
      .out_ready (pw_ready),
      .out_ctl   (pw_ctl),
      .out_power (pw_power)
   );

   // ring of kept bin totals: head holds the bin now arriving, tail takes the
   // updated total; one shift per kept bin keeps the ring in bin order
   assign rdy4       = !v4_ff || grp_ready;
   assign pw_ready   = rdy4;
   assign ring_shift = pw_valid && rdy4 && pw_ctl.kept;
   assign new_total  = (pw_ctl.first ? '0 : cell_q[0]) + TOTAL_W'(pw_power);

   for (genvar i = 0; i < NCELL; i++) begin : g_ring
      if (i == NCELL - 1) begin : g_tail
         assign chain_in[i] = new_total;
      end else begin : g_link
         assign chain_in[i] = cell_q[i+1];
      end
      spi_cell u_cell (
         .clock   (clock),
         .shift   (ring_shift),
         .link_in (chain_in[i]),
         .value   (cell_q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (rdy4) begin
         v4_ff <= pw_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         ctl4_ff   <= pw_ctl;
         total4_ff <= new_total;
      end
   end

   spi_group u_group (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (v4_ff),
      .in_ready   (grp_ready),
      .in_ctl     (ctl4_ff),
      .in_total   (total4_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_frame_bound: assert property (@(posedge clock) disable iff (reset)
      32'(frame_pos_ff) < MAX_AVG)
      else $error("frame position beyond the largest average");

   a_bin_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && bin_wrap |=> bin_pos_ff == '0)
      else $error("bin position did not wrap after the last bin");

   a_total_hold: assert property (@(posedge clock) disable iff (reset)
      v4_ff && !grp_ready |=> v4_ff && $stable(total4_ff) && $stable(ctl4_ff))
      else $error("bin total lost while the group stage stalled");

   a_emit_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(v4_ff))
      else $error("result loaded without a bin total");

endmodule

`default_nettype wire
